>>> rtl/qalu_pkg.sv
`timescale 1ns / 1ps

package qalu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DW        = 32;             // component width
   localparam int NL        = 4;              // lanes, one per component
   localparam int PW        = 2 * DW;         // full product
   localparam int AW        = PW + 2;         // signed sum of four products
   localparam int MW        = PW + 1;         // magnitude of such a sum
   localparam int NW        = MW + FRAC_BITS; // scaled dividend
   localparam int QW        = 32;             // quotient / root bits resolved
   localparam int CW        = MW + QW;        // divider compare width
   localparam int NSTAGE    = 3 + QW + 1;     // register stages ahead of the output
   localparam int IN_W      = 9 * DW;
   localparam int OUT_W     = NL * DW;

   localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_SCALE = 3'd4,
      OP_SDIV  = 3'd5,
      OP_NORM  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_DZ  = 2'd1,
      ST_SAT = 2'd2
   } status_type;

   typedef logic [NL-1:0][DW-1:0] quat_type;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          sat;
   } sat_type;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          sat;
      logic          dz;
   } lane_res_type;

   // negated terms per lane, bit t for term t
   localparam logic [NL-1:0] MUL_NEG [NL] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};
   localparam logic [NL-1:0] DIV_NEG [NL] = '{4'b0000, 4'b0110, 4'b1100, 4'b1010};

   function automatic sat_type sat32(input logic signed [AW-1:0] v);
      sat_type r;
      if (v[AW-1:DW-1] == '0 || v[AW-1:DW-1] == '1) begin
         r.val = v[DW-1:0];
         r.sat = 1'b0;
      end else begin
         r.val = v[AW-1] ? SAT_MIN : SAT_MAX;
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/qalu_lane.sv
`timescale 1ns / 1ps

module qalu_lane (
   input  logic                    clock,
   input  logic                    en,
   input  qalu_pkg::op_type        op,
   input  logic [1:0]              lane_id,
   input  qalu_pkg::quat_type      a,
   input  qalu_pkg::quat_type      b,
   input  logic [qalu_pkg::DW-1:0] scalar,
   input  logic [qalu_pkg::MW-1:0] den_sq,
   output qalu_pkg::lane_res_type  res
);
   import qalu_pkg::*;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [MW-1:0] den;
      logic [QW-1:0] quo;
      logic          neg;
      logic          ovf;
      logic          dz;
      logic          divmode;
      logic [DW-1:0] val;
      logic          sat;
   } div_type;

   // products
   logic [DW-1:0]        xs [NL];
   logic [DW-1:0]        ys [NL];
   logic signed [PW-1:0] prod_in [NL];
   logic signed [PW-1:0] prod_ff [NL];
   logic [NL-1:0]        pneg_in, pneg_ff;
   logic signed [AW-1:0] lin_in, lin_ff;
   op_type               op1_ff, op2_ff;
   logic [DW-1:0]        s1_ff, s2_ff;

   always_comb begin
      pneg_in = '0;
      lin_in  = '0;
      for (int t = 0; t < NL; t++) begin
         xs[t] = '0;
         ys[t] = '0;
      end
      case (op)
         OP_MUL: begin
            for (int t = 0; t < NL; t++) begin
               xs[t] = a[t];
               ys[t] = b[2'(t) ^ lane_id];
            end
            pneg_in = MUL_NEG[lane_id];
         end
         OP_DIV: begin
            for (int t = 0; t < NL; t++) begin
               xs[t] = a[2'(t) ^ lane_id];
               ys[t] = b[t];
            end
            pneg_in = DIV_NEG[lane_id];
         end
         OP_SCALE: begin
            xs[0] = a[lane_id];
            ys[0] = scalar;
         end
         OP_ADD:  lin_in = AW'($signed(a[lane_id])) + AW'($signed(b[lane_id]));
         OP_SUB:  lin_in = AW'($signed(a[lane_id])) - AW'($signed(b[lane_id]));
         OP_SDIV: lin_in = AW'($signed(a[lane_id]));
         default: ;
      endcase
      for (int t = 0; t < NL; t++) begin
         prod_in[t] = PW'($signed(xs[t])) * PW'($signed(ys[t]));
      end
   end

   // signed sum
   logic signed [AW-1:0] acc_in, acc_ff;

   always_comb begin
      acc_in = lin_ff;
      for (int t = 0; t < NL; t++) begin
         acc_in = pneg_ff[t] ? acc_in - AW'(prod_ff[t]) : acc_in + AW'(prod_ff[t]);
      end
   end

   // prep: saturate the direct results, set up the divider
   div_type              div_in [QW+1];
   div_type              div_ff [QW+1];
   logic [MW-1:0]        mag;
   logic [NW-1:0]        num;
   logic [DW:0]          sabs;
   logic signed [AW-1:0] shr;
   sat_type              sv;

   always_comb begin
      mag  = acc_ff[AW-1] ? MW'(-acc_ff) : MW'(acc_ff);
      num  = NW'(mag) << FRAC_BITS;
      sabs = s2_ff[DW-1] ? -{s2_ff[DW-1], s2_ff} : {1'b0, s2_ff};
      shr  = acc_ff >>> FRAC_BITS;
      sv   = '0;
      div_in[0] = '0;
      case (op2_ff) inside
         OP_ADD, OP_SUB: begin
            sv = sat32(acc_ff);
            div_in[0].val = sv.val;
            div_in[0].sat = sv.sat;
         end
         OP_MUL, OP_SCALE: begin
            sv = sat32(shr);
            div_in[0].val = sv.val;
            div_in[0].sat = sv.sat;
         end
         OP_DIV, OP_SDIV: begin
            div_in[0].divmode = 1'b1;
            div_in[0].rem     = num;
            div_in[0].den     = (op2_ff == OP_DIV) ? den_sq : MW'(sabs);
            div_in[0].neg     = acc_ff[AW-1] ^ ((op2_ff == OP_SDIV) && s2_ff[DW-1]);
            div_in[0].dz      = (div_in[0].den == '0);
            div_in[0].ovf     = (CW'(num) >= {div_in[0].den, {QW{1'b0}}});
         end
         default: ;
      endcase
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [CW-1:0] rext, dsh;
      always_comb begin
         div_in[k+1] = div_ff[k];
         rext        = CW'(div_ff[k].rem);
         dsh         = CW'(div_ff[k].den) << (QW - 1 - k);
         if (div_ff[k].divmode && rext >= dsh) begin
            div_in[k+1].rem            = NW'(rext - dsh);
            div_in[k+1].quo[QW-1-k]    = 1'b1;
         end
      end
   end

   // sign and saturate the quotient
   lane_res_type res_in, res_ff;
   div_type      df;

   always_comb begin
      df     = div_ff[QW];
      res_in = '0;
      if (df.divmode) begin
         if (df.dz) begin
            res_in.dz = 1'b1;
         end else if (df.ovf || (df.neg ? (df.quo > SAT_MIN) : df.quo[QW-1])) begin
            res_in.sat = 1'b1;
            res_in.val = df.neg ? SAT_MIN : SAT_MAX;
         end else begin
            res_in.val = df.neg ? DW'(-df.quo) : DW'(df.quo);
         end
      end else begin
         res_in.val = df.val;
         res_in.sat = df.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         pneg_ff <= pneg_in;
         lin_ff  <= lin_in;
         op1_ff  <= op;
         s1_ff   <= scalar;
         acc_ff  <= acc_in;
         op2_ff  <= op1_ff;
         s2_ff   <= s1_ff;
         div_ff  <= div_in;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

>>> rtl/qalu_mag.sv
`timescale 1ns / 1ps

module qalu_mag (
   input  logic                    clock,
   input  logic                    en,
   input  qalu_pkg::op_type        op,
   input  qalu_pkg::quat_type      a,
   input  qalu_pkg::quat_type      b,
   output logic [qalu_pkg::MW-1:0] den_sq,
   output qalu_pkg::sat_type       norm
);
   import qalu_pkg::*;

   typedef struct packed {
      logic [PW-1:0] rem;
      logic [QW-1:0] root;
      logic          big;
   } sqrt_type;

   // squares of b for divide, of a otherwise
   logic [DW-1:0] xs [NL];
   logic [PW-1:0] sq_in [NL];
   logic [PW-1:0] sq_ff [NL];

   always_comb begin
      for (int t = 0; t < NL; t++) begin
         xs[t]    = (op == OP_DIV) ? b[t] : a[t];
         sq_in[t] = PW'(PW'($signed(xs[t])) * PW'($signed(xs[t])));
      end
   end

   logic [MW-1:0] sum_in, sum_ff;

   always_comb begin
      sum_in = '0;
      for (int t = 0; t < NL; t++) begin
         sum_in = sum_in + MW'(sq_ff[t]);
      end
   end

   assign den_sq = sum_ff;

   // one root bit per stage
   sqrt_type sqrt_in [QW+1];
   sqrt_type sqrt_ff [QW+1];

   always_comb begin
      sqrt_in[0].rem  = sum_ff[PW-1:0];
      sqrt_in[0].root = '0;
      sqrt_in[0].big  = sum_ff[MW-1];
   end

   for (genvar k = 0; k < QW; k++) begin : g_sqrt
      logic [PW+1:0] rext, trial;
      always_comb begin
         sqrt_in[k+1] = sqrt_ff[k];
         rext         = (PW+2)'(sqrt_ff[k].rem);
         trial        = ((PW+2)'(sqrt_ff[k].root) << (QW - k))
                      + ((PW+2)'(1) << (2 * (QW - 1 - k)));
         if (rext >= trial) begin
            sqrt_in[k+1].rem           = PW'(rext - trial);
            sqrt_in[k+1].root[QW-1-k]  = 1'b1;
         end
      end
   end

   sat_type norm_in, norm_ff;

   always_comb begin
      if (sqrt_ff[QW].big || sqrt_ff[QW].root[QW-1]) begin
         norm_in.val = SAT_MAX;
         norm_in.sat = 1'b1;
      end else begin
         norm_in.val = DW'(sqrt_ff[QW].root);
         norm_in.sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
         sqrt_ff <= sqrt_in;
         norm_ff <= norm_in;
      end
   end

   assign norm = norm_ff;

endmodule

>>> rtl/quaternion_alu_top.sv
`timescale 1ns / 1ps
// quaternion alu on signed q16.16 components, fully pipelined
// most of the pipe is the 32 stage quotient and root pipelines
// throughput: one item per cycle while results are taken, every stage is registered
// the whole pipe holds while a result waits at the output register
// reset (synchronous, active high) clears the valid chain and the output valid

module quaternion_alu_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scalar
   input  logic [qalu_pkg::IN_W-1:0]  req_tdata,
   // op
   input  logic [2:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // r_real, r_i, r_j, r_k
   output logic [qalu_pkg::OUT_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                 rsp_tuser
);
   import qalu_pkg::*;

   // pipe advances unless a result is parked at the output
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // unpack the input item
   quat_type      a, b;
   logic [DW-1:0] scalar;
   op_type        op;

   always_comb begin
      for (int t = 0; t < NL; t++) begin
         a[t] = req_tdata[t*DW +: DW];
         b[t] = req_tdata[(NL+t)*DW +: DW];
      end
      scalar = req_tdata[2*NL*DW +: DW];
      op     = op_type'(req_tuser);
   end

   // one lane per result component
   lane_res_type  lres [NL];
   logic [MW-1:0] den_sq;
   sat_type       norm;

   for (genvar i = 0; i < NL; i++) begin : g_lane
      qalu_lane u_lane (
         .clock   (clock),
         .en      (en),
         .op      (op),
         .lane_id (2'(i)),
         .a       (a),
         .b       (b),
         .scalar  (scalar),
         .den_sq  (den_sq),
         .res     (lres[i])
      );
   end

   // |b|^2 for divide, |a| for norm
   qalu_mag u_mag (
      .clock  (clock),
      .en     (en),
      .op     (op),
      .a      (a),
      .b      (b),
      .den_sq (den_sq),
      .norm   (norm)
   );

   // valid and op travel beside the lanes
   logic [NSTAGE-1:0] vld_in, vld_ff;
   op_type            op_ff [NSTAGE];

   assign vld_in = {vld_ff[NSTAGE-2:0], req_tvalid && req_tready};

   // merge: pick the norm, flag division by zero, collect saturation
   logic [OUT_W-1:0] rsp_data_in, rsp_data_ff;
   status_type       rsp_user_in, rsp_user_ff;
   logic             rsp_tvalid_ff;
   logic             sat_any;

   always_comb begin
      sat_any     = 1'b0;
      rsp_data_in = '0;
      for (int i = 0; i < NL; i++) begin
         sat_any = sat_any | lres[i].sat;
      end
      if (op_ff[NSTAGE-1] == OP_NORM) begin
         rsp_data_in[DW-1:0] = norm.val;
         rsp_user_in         = norm.sat ? ST_SAT : ST_OK;
      end else if (lres[0].dz) begin
         rsp_user_in = ST_DZ;
      end else begin
         for (int i = 0; i < NL; i++) begin
            rsp_data_in[i*DW +: DW] = lres[i].val;
         end
         rsp_user_in = sat_any ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= vld_ff[NSTAGE-1];
      end
      if (en) begin
         op_ff[0] <= op;
         for (int k = 1; k < NSTAGE; k++) begin
            op_ff[k] <= op_ff[k-1];
         end
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   // a division by zero returns all zero components
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DZ |-> rsp_tdata == '0)
      else $error("division by zero item carries nonzero data");

   // a result appears only when an item reached the end of the pipe
   a_vld_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(vld_ff[NSTAGE-1]))
      else $error("result valid without an item in the last stage");
`endif

endmodule

>>> tb/quaternion_alu_top_tb.sv
`timescale 1ns / 1ps

module quaternion_alu_top_tb;
   import qalu_pkg::*;

   localparam int MAX_CYCLES = 200000;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] a [4];
      logic [31:0] b [4];
      logic [31:0] s;
   } quat_op_type;

   typedef struct {
      logic [31:0] r [4];
      logic [1:0]  status;
   } quat_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   quat_op_type pending_ops [$];
   quat_res_type expected_res [$];
   int errors = 0;
   int cycles = 0;
   bit stim_done = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   quaternion_alu_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clamp a wide signed value to 32 bits, flagging saturation
   function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // num * 2^16 / den, truncated toward zero
   function automatic logic signed [127:0] fix_div(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
      logic signed [127:0] n;
      n = num <<< FRAC_BITS;
      return n / den;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] root;
      root = 0;
      for (int bitpos = 31; bitpos >= 0; bitpos--) begin
         logic [63:0] t;
         t = root | (64'd1 << bitpos);
         if (t * t <= x) root = t;
      end
      return root;
   endfunction

   function automatic quat_res_type quat_compute(input quat_op_type it);
      quat_res_type res;
      logic signed [127:0] a [4], b [4], w [4], d, s;
      bit sat, dz;
      sat = 0;
      dz = 0;
      s = $signed(it.s);
      for (int i = 0; i < 4; i++) begin
         a[i] = $signed(it.a[i]);
         b[i] = $signed(it.b[i]);
         w[i] = 0;
      end
      case (it.op)
         OP_ADD: for (int i = 0; i < 4; i++) w[i] = a[i] + b[i];
         OP_SUB: for (int i = 0; i < 4; i++) w[i] = a[i] - b[i];
         OP_MUL: begin
            w[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
            w[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
            w[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
            w[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
            for (int i = 0; i < 4; i++) w[i] = w[i] >>> FRAC_BITS;
         end
         OP_DIV: begin
            d = b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3];
            if (d == 0) dz = 1;
            else begin
               w[0] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
               w[1] = a[1]*b[0] - a[0]*b[1] - a[3]*b[2] + a[2]*b[3];
               w[2] = a[2]*b[0] + a[3]*b[1] - a[0]*b[2] - a[1]*b[3];
               w[3] = a[3]*b[0] - a[2]*b[1] + a[1]*b[2] - a[0]*b[3];
               for (int i = 0; i < 4; i++) w[i] = fix_div(w[i], d);
            end
         end
         OP_SCALE: for (int i = 0; i < 4; i++) w[i] = (a[i] * s) >>> FRAC_BITS;
         OP_SDIV: begin
            if (s == 0) dz = 1;
            else for (int i = 0; i < 4; i++) w[i] = fix_div(a[i], s);
         end
         OP_NORM: begin
            d = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
            // sums beyond 64 bits pin the root at 2^32
            if (d[127:64] != 0) w[0] = 128'sd1 << 32;
            else w[0] = int_sqrt(d[63:0]);
         end
         default: ;
      endcase
      for (int i = 0; i < 4; i++) res.r[i] = dz ? 32'd0 : clamp32(w[i], sat);
      res.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
      return res;
   endfunction

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'd0;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         5: return 32'($signed(20'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   task automatic push_op(input logic [2:0] op, input logic [31:0] av, input logic [31:0] bv,
                          input logic [31:0] sv);
      quat_op_type it;
      it.op = op;
      for (int i = 0; i < 4; i++) begin
         it.a[i] = av;
         it.b[i] = bv;
      end
      it.s = sv;
      pending_ops.push_back(it);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   task automatic it_drive(input quat_op_type it);
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {it.s, it.b[3], it.b[2], it.b[1], it.b[0],
                    it.a[3], it.a[2], it.a[1], it.a[0]};
   endtask

   // stimulus: directed corners, then random items
   initial begin
      quat_op_type it;
      for (int op = 0; op < 8; op++) begin
         push_op(3'(op), 32'h7fffffff, 32'h80000000, 32'h80000000);
         push_op(3'(op), 32'h00020000, 32'h00010000, 32'd0);
         push_op(3'(op), 32'h80000000, 32'h7fffffff, 32'hffffffff);
      end
      push_op(OP_DIV, 32'h00010000, 32'd0, 32'd1);
      repeat (800) begin
         it.op = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
         for (int i = 0; i < 4; i++) begin
            it.a[i] = rand_comp();
            it.b[i] = rand_comp();
         end
         // some divisions by zero
         if ($urandom_range(0, 9) == 0) for (int i = 0; i < 4; i++) it.b[i] = 0;
         it.s = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_comp();
         pending_ops.push_back(it);
      end
      stim_done = 1'b1;
   end

   // driver: presents queued items with random gaps
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 5) reset <= 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_res.push_back(quat_compute(pending_ops.pop_front()));
            send_gap = $urandom_range(0, 5);
         end
         if (req_tvalid && !req_tready) begin
            // hold the current item
         end else if (send_gap > 0 || pending_ops.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_tvalid <= 1'b0;
         end else begin
            it_drive(pending_ops[0]);
         end
      end
   end

   // monitor: random back-pressure and result check
   always @(posedge clock) begin
      quat_res_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_res.size() == 0) begin
               report("unexpected item", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_res.pop_front();
               for (int i = 0; i < 4; i++)
                  if (rsp_tdata[i*32 +: 32] !== want.r[i])
                     report($sformatf("r[%0d]", i), rsp_tdata[i*32 +: 32], want.r[i]);
               if (rsp_tuser !== want.status)
                  report("status", 32'(rsp_tuser), 32'(want.status));
            end
            recv_gap = $urandom_range(0, 5);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done && !reset);
      while ((pending_ops.size() != 0 || expected_res.size() != 0 || req_tvalid)
             && cycles < MAX_CYCLES)
         @(posedge clock);
      if (cycles >= MAX_CYCLES) begin
         $display("[quaternion_alu_top] ERROR");
         $finish;
      end else begin
         repeat (60) @(posedge clock);
         if (errors == 0 && expected_res.size() == 0) begin
            $display("[quaternion_alu_top] OK");
         end else begin
            $display("[quaternion_alu_top] ERROR");
         end
         $finish;
      end
   end

endmodule
